// ===== src/brb_pkg.sv =====
// shared types and constants for the byte ring buffer
// no dependencies; used by every module under src except brb_ram
package brb_pkg;

  localparam int SLOTS   = 1024;
  localparam int LANES   = 8;
  localparam int SEQ_W   = $clog2(SLOTS);
  localparam int LANE_W  = $clog2(LANES);
  localparam int ROWS    = SLOTS / LANES;
  localparam int ROW_W   = $clog2(ROWS);
  localparam int RING_W  = 11;
  localparam int CNT_W   = 4;
  localparam int DATA_W  = 64;
  localparam int USED_W  = 10;
  localparam int PADDR_W = 3;

  localparam logic [RING_W-1:0] RING_MIN = RING_W'(2);
  localparam logic [RING_W-1:0] RING_MAX = RING_W'(SLOTS);
  localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(LANES);

  typedef enum logic [1:0] {
    KIND_ENQ   = 2'd0,
    KIND_DEQ   = 2'd1,
    KIND_PEEK  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [PADDR_W-3:0] {
    REG_RING_SLOTS = 1'b0
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CNT_W-1:0]  byte_count;
    logic [DATA_W-1:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic [DATA_W-1:0] data_out;
    logic [USED_W-1:0] used_count;
    logic [USED_W-1:0] free_count;
  } out_item_t;

  // per-item control broadcast to every lane
  typedef struct packed {
    logic             wr;
    logic             rd;
    logic [SEQ_W-1:0] base;
    logic [CNT_W-1:0] count;
  } lane_ctl_t;

  // what the merging stage needs to line up the read bytes
  typedef struct packed {
    logic              show;
    logic [LANE_W-1:0] off;
    logic [CNT_W-1:0]  count;
  } merge_ctl_t;

endpackage

// ===== src/brb_ram.sv =====
// generic simple dual-port ram with registered read
// no dependencies
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/brb_lane.sv =====
// one byte lane: address generation and its storage bank
// depends on brb_pkg and brb_ram
module brb_lane (
  input  logic                      clk,
  input  logic [brb_pkg::LANE_W-1:0] lane_id,
  input  brb_pkg::lane_ctl_t        ctl,
  input  logic [brb_pkg::DATA_W-1:0] data_in,
  output logic [7:0]                rdata
);

  logic [brb_pkg::LANE_W-1:0] off;
  logic [brb_pkg::LANE_W-1:0] idx;
  logic                       active;
  logic [brb_pkg::ROW_W-1:0]  row;
  logic [7:0]                 wbyte;

  // byte idx of the transfer lands in this bank
  assign off    = ctl.base[brb_pkg::LANE_W-1:0];
  assign idx    = lane_id - off;
  assign active = brb_pkg::CNT_W'(idx) < ctl.count;
  assign row    = ctl.base[brb_pkg::SEQ_W-1:brb_pkg::LANE_W]
                + brb_pkg::ROW_W'(lane_id < off);
  assign wbyte  = data_in[{idx, 3'b000} +: 8];

  brb_ram #(
    .WIDTH(8),
    .DEPTH(brb_pkg::ROWS)
  ) u_bank (
    .clk  (clk),
    .we   (ctl.wr && active),
    .waddr(row),
    .wdata(wbyte),
    .re   (ctl.rd && active),
    .raddr(row),
    .rdata(rdata)
  );

endmodule

// ===== src/brb_merge.sv =====
// merging stage: rotates lane read data into item order and masks unused bytes
// depends on brb_pkg
module brb_merge (
  input  logic [brb_pkg::LANES-1:0][7:0] lane_data,
  input  brb_pkg::merge_ctl_t            ctl,
  output logic [brb_pkg::DATA_W-1:0]     data_out
);

  logic [brb_pkg::LANE_W-1:0] src;

  always_comb begin
    data_out = '0;
    src      = '0;
    for (int j = 0; j < brb_pkg::LANES; j++) begin
      src = ctl.off + brb_pkg::LANE_W'(j);
      if (ctl.show && (brb_pkg::CNT_W'(j) < ctl.count)) begin
        data_out[8*j +: 8] = lane_data[src];
      end
    end
  end

endmodule

// ===== src/byte_ring_buffer_top.sv =====
// byte ring buffer, one slot kept empty; the result is registered when the item is accepted
// throughput one item per cycle while results are taken: every lane bank is touched once per item
// in_ready is high whenever the output register is empty or being taken
// reset (synchronous, rst_n low): positions to zero, ring_slots to 1024, output empty
// byte storage is not cleared and needs no clearing pass after reset
// depends on brb_pkg, brb_lane, brb_merge
module byte_ring_buffer_top (
  input  logic                         clk,
  input  logic                         rst_n,
  // item input
  input  logic                         in_valid,
  output logic                         in_ready,
  input  brb_pkg::in_item_t            in_item,
  // result output
  output logic                         out_valid,
  input  logic                         out_ready,
  output brb_pkg::out_item_t           out_item,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [brb_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  // bytes are stored by running sequence number modulo the storage size rather
  // than by ring position; because the capacity never exceeds the storage size
  // less one, live bytes never collide, and any run of up to eight consecutive
  // sequence numbers falls in eight different banks
  logic [brb_pkg::SEQ_W-1:0]  rd_seq_r, rd_seq_nxt;
  logic [brb_pkg::SEQ_W-1:0]  wr_seq_r, wr_seq_nxt;
  logic [brb_pkg::RING_W-1:0] ring_slots_r, ring_slots_nxt;

  // output register
  logic                        out_valid_r;
  logic                        status_r, status_nxt;
  logic [brb_pkg::USED_W-1:0]  used_r, used_nxt;
  logic [brb_pkg::USED_W-1:0]  free_r, free_nxt;
  brb_pkg::merge_ctl_t         mctl_r, mctl_nxt;

  logic                        accept;
  logic                        cfg_wr;
  logic [brb_pkg::RING_W-1:0]  cfg_val;
  logic [brb_pkg::USED_W-1:0]  cap;
  logic [brb_pkg::USED_W-1:0]  used;
  logic [brb_pkg::USED_W-1:0]  cnt_ext;
  brb_pkg::lane_ctl_t          lctl;
  logic [brb_pkg::LANES-1:0][7:0] lane_data;
  logic [brb_pkg::DATA_W-1:0]  merged;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // configuration: one register, clamped into range on write
  assign pready = 1'b1;
  assign prdata = 32'(ring_slots_r);
  assign cfg_wr = psel && penable && pwrite && pready
               && (paddr[brb_pkg::PADDR_W-1:2] == brb_pkg::REG_RING_SLOTS);

  always_comb begin
    cfg_val = pwdata[brb_pkg::RING_W-1:0];
    if (cfg_val < brb_pkg::RING_MIN) begin
      cfg_val = brb_pkg::RING_MIN;
    end else if (cfg_val > brb_pkg::RING_MAX) begin
      cfg_val = brb_pkg::RING_MAX;
    end
  end

  // occupancy from the sequence numbers; capacity is one below the slot count
  assign cap     = brb_pkg::USED_W'(ring_slots_r - brb_pkg::RING_W'(1));
  assign used    = wr_seq_r - rd_seq_r;
  assign cnt_ext = brb_pkg::USED_W'(in_item.byte_count);

  // operation decision and pointer update
  always_comb begin
    rd_seq_nxt     = rd_seq_r;
    wr_seq_nxt     = wr_seq_r;
    ring_slots_nxt = ring_slots_r;
    status_nxt     = 1'b0;
    lctl           = '0;
    lctl.count     = in_item.byte_count;
    lctl.base      = wr_seq_r;
    mctl_nxt       = '0;
    mctl_nxt.count = in_item.byte_count;
    mctl_nxt.off   = rd_seq_r[brb_pkg::LANE_W-1:0];

    if (cfg_wr) begin
      ring_slots_nxt = cfg_val;
      rd_seq_nxt     = '0;
      wr_seq_nxt     = '0;
    end else if (accept) begin
      case (in_item.kind)
        brb_pkg::KIND_CLEAR: begin
          rd_seq_nxt = '0;
          wr_seq_nxt = '0;
        end
        brb_pkg::KIND_ENQ: begin
          if (in_item.byte_count > brb_pkg::CNT_MAX || used >= cap
              || (cap - used) < cnt_ext) begin
            status_nxt = 1'b1;
          end else begin
            lctl.wr    = 1'b1;
            wr_seq_nxt = wr_seq_r + brb_pkg::SEQ_W'(in_item.byte_count);
          end
        end
        brb_pkg::KIND_DEQ, brb_pkg::KIND_PEEK: begin
          lctl.base = rd_seq_r;
          if (in_item.byte_count > brb_pkg::CNT_MAX || used == '0
              || used < cnt_ext) begin
            status_nxt = 1'b1;
          end else begin
            lctl.rd       = 1'b1;
            mctl_nxt.show = 1'b1;
            if (in_item.kind == brb_pkg::KIND_DEQ) begin
              rd_seq_nxt = rd_seq_r + brb_pkg::SEQ_W'(in_item.byte_count);
            end
          end
        end
        default: begin
          status_nxt = 1'b1;
        end
      endcase
    end

    used_nxt = wr_seq_nxt - rd_seq_nxt;
    free_nxt = cap - used_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_seq_r     <= '0;
      wr_seq_r     <= '0;
      ring_slots_r <= brb_pkg::RING_MAX;
      out_valid_r  <= 1'b0;
    end else begin
      rd_seq_r     <= rd_seq_nxt;
      wr_seq_r     <= wr_seq_nxt;
      ring_slots_r <= ring_slots_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      used_r   <= used_nxt;
      free_r   <= free_nxt;
      mctl_r   <= mctl_nxt;
    end
  end

  // byte lanes, one bank each; bank read data holds until the next read item
  for (genvar g = 0; g < brb_pkg::LANES; g++) begin : g_lane
    brb_lane u_lane (
      .clk    (clk),
      .lane_id(brb_pkg::LANE_W'(g)),
      .ctl    (lctl),
      .data_in(in_item.data_in),
      .rdata  (lane_data[g])
    );
  end

  // put the read bytes back into item order
  brb_merge u_merge (
    .lane_data(lane_data),
    .ctl      (mctl_r),
    .data_out (merged)
  );

  always_comb begin
    out_item            = '0;
    out_item.status     = status_r;
    out_item.data_out   = merged;
    out_item.used_count = used_r;
    out_item.free_count = free_r;
  end

endmodule

// ===== tb/tb_byte_ring_buffer_top.sv =====
// self-checking testbench for byte_ring_buffer_top: directed table, then random phases
// predicts results from its own ring model or a pinned row; depends on brb_pkg and the rtl under src
`timescale 1ns / 100ps

module tb_byte_ring_buffer_top;
  import brb_pkg::*;

  localparam int LIMIT = 200_000;   // cycles, many times the slowest correct run

  // one row of the directed table; want is only used where pinned is set
  typedef struct packed {
    kind_t            kind;
    logic [CNT_W-1:0] cnt;
    logic [DATA_W-1:0] data;
    logic             pinned;
    out_item_t        want;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_item;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_item;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // ring model: slot count in use, positions and stored bytes
  int                  ring_n;
  int                  rd_p;
  int                  wr_p;
  logic [7:0]          ring_store [SLOTS];

  out_item_t           pending_results [$];
  dir_row_t            dir_tab [$];
  logic                pin_on;
  out_item_t           pin_res;
  out_item_t           next_want;
  logic                filling;
  int                  in_idle;
  int                  out_stall;
  int                  cycles;
  int                  items_sent;
  int                  results_checked;
  int                  resizes;
  int                  mismatches;

  byte_ring_buffer_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // ring model
  // ---------------------------------------------------------------------------

  // bytes held; one slot always stays empty so wr_p == rd_p means empty
  function automatic int held_bytes();
    return (wr_p >= rd_p) ? wr_p - rd_p : ring_n - (rd_p - wr_p);
  endfunction

  // applies one item to the ring model and returns the result it should give
  function automatic out_item_t ring_apply(in_item_t it);
    out_item_t r;
    int        cap;
    int        held;
    int        n;
    int        p;
    cap  = ring_n - 1;
    held = held_bytes();
    n    = it.byte_count;
    r    = '0;
    case (kind_t'(it.kind))
      KIND_CLEAR: begin
        rd_p = 0;
        wr_p = 0;
      end
      KIND_ENQ: begin
        // transfers are all or nothing; a full ring refuses even a zero count
        if (n > LANES || held >= cap || cap - held < n) begin
          r.status = 1'b1;
        end else begin
          for (int i = 0; i < n; i++) begin
            ring_store[wr_p] = it.data_in[8*i +: 8];
            wr_p = (wr_p + 1 == ring_n) ? 0 : wr_p + 1;
          end
        end
      end
      default: begin
        // dequeue and peek: an empty ring refuses even a zero count
        if (n > LANES || held == 0 || held < n) begin
          r.status = 1'b1;
        end else begin
          p = rd_p;
          for (int i = 0; i < n; i++) begin
            r.data_out[8*i +: 8] = ring_store[p];
            p = (p + 1 == ring_n) ? 0 : p + 1;
          end
          if (kind_t'(it.kind) == KIND_DEQ) rd_p = p;
        end
      end
    endcase
    held         = held_bytes();
    r.used_count = USED_W'(held);
    r.free_count = USED_W'(cap - held);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // checking: results against the oldest expectation, items into the model
  // ---------------------------------------------------------------------------

  task automatic note_fail(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      note_fail($sformatf("result %h with no item outstanding", got));
    end else begin
      want = pending_results.pop_front();
      results_checked++;
      if (got.status !== want.status)
        note_fail($sformatf("status exp %0b got %0b", want.status, got.status));
      if (got.data_out !== want.data_out)
        note_fail($sformatf("data_out exp %h got %h", want.data_out, got.data_out));
      if (got.used_count !== want.used_count)
        note_fail($sformatf("used_count exp %0d got %0d", want.used_count, got.used_count));
      if (got.free_count !== want.free_count)
        note_fail($sformatf("free_count exp %0d got %0d", want.free_count, got.free_count));
    end
  endtask

  // sampled at the rising edge, before any register in the block moves;
  // a result at this edge always belongs to an earlier item, so check first
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) check_result(out_item);
      if (in_valid && in_ready) begin
        next_want = ring_apply(in_item);
        if (pin_on) next_want = pin_res;
        pending_results.push_back(next_want);
        items_sent++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("tb_byte_ring_buffer_top: FAIL");
      $finish;
    end
  end

  // receiver back-pressure, redrawn every falling edge
  always @(negedge clk) out_ready <= ($urandom_range(99) >= out_stall);

  // ---------------------------------------------------------------------------
  // drivers, all called and returning at a falling edge
  // ---------------------------------------------------------------------------

  // offers one item, with random gaps in front, and holds it until taken
  task automatic send_item(input in_item_t it, input logic pinned, input out_item_t pin);
    while ($urandom_range(99) < in_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    pin_on   <= pinned;
    pin_res  <= pin;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // lets every outstanding result come back, then idles with the input quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  // write of ring_slots in a setup and an access phase; the model clamps and clears its positions too
  task automatic write_slots(input logic [31:0] value);
    int v;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_RING_SLOTS, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    v      = value[RING_W-1:0];
    ring_n = (v < RING_MIN) ? RING_MIN : (v > RING_MAX) ? RING_MAX : v;
    rd_p   = 0;
    wr_p   = 0;
    resizes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic dir_row_t row(kind_t k, int c, logic [DATA_W-1:0] d, logic p,
                                   logic st, logic [DATA_W-1:0] dout, int used, int free);
    dir_row_t r;
    r.kind            = k;
    r.cnt             = CNT_W'(c);
    r.data            = d;
    r.pinned          = p;
    r.want.status     = st;
    r.want.data_out   = dout;
    r.want.used_count = USED_W'(used);
    r.want.free_count = USED_W'(free);
    return r;
  endfunction

  // mostly well-formed traffic that swings between filling and draining the
  // ring, so full and empty are both reached; a little noise and clearing
  function automatic in_item_t pick_item(int clr_pct);
    in_item_t it;
    int       cap;
    int       held;
    int       room;
    int       lim;
    int       r;
    cap        = ring_n - 1;
    held       = held_bytes();
    it.data_in = {$urandom, $urandom};
    if (filling && held == cap && $urandom_range(3) == 0) filling = 1'b0;
    else if (!filling && held == 0 && $urandom_range(3) == 0) filling = 1'b1;
    else if (cap < 256 && $urandom_range(49) == 0) filling = !filling;
    r = $urandom_range(99);
    if (r < clr_pct) begin
      it.kind       = KIND_CLEAR;
      it.byte_count = CNT_W'($urandom_range(15));
    end else if (r < clr_pct + 5) begin
      // oversized count on a transfer
      it.kind       = kind_t'($urandom_range(2));
      it.byte_count = CNT_W'($urandom_range(15, 9));
    end else begin
      r = $urandom_range(9);
      if (filling) it.kind = (r < 9) ? KIND_ENQ : KIND_PEEK;
      else         it.kind = (r < 6) ? KIND_DEQ : (r < 8) ? KIND_PEEK : KIND_ENQ;
      room = (kind_t'(it.kind) == KIND_ENQ) ? cap - held : held;
      lim  = (room > LANES) ? LANES : room;
      // lean on the largest transfer that still fits, sometimes anything
      if (lim > 0 && $urandom_range(3) != 0)
        it.byte_count = CNT_W'($urandom_range(1) ? lim : $urandom_range(lim, 1));
      else
        it.byte_count = CNT_W'($urandom_range(LANES));
    end
    return it;
  endfunction

  task automatic run_phase(input logic [31:0] slots, input int idle_pct, input int stall_pct,
                           input int clr_pct, input int n_items);
    in_item_t it;
    settle();
    write_slots(slots);
    in_idle   = idle_pct;
    out_stall = stall_pct;
    filling   = 1'b1;
    repeat (n_items) begin
      it = pick_item(clr_pct);
      send_item(it, 1'b0, '0);
    end
  endtask

  initial begin
    in_item_t it;
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_item         = '0;
    out_ready       = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    pin_on          = 1'b0;
    pin_res         = '0;
    filling         = 1'b1;
    in_idle         = 0;
    out_stall       = 0;
    cycles          = 0;
    items_sent      = 0;
    results_checked = 0;
    resizes         = 0;
    mismatches      = 0;
    // model after reset: full-size ring, both positions at zero
    ring_n          = SLOTS;
    rd_p            = 0;
    wr_p            = 0;
    foreach (ring_store[i]) ring_store[i] = '0;

    // directed part on the reset-size ring (capacity 1023); results typed in
    // where they are plain, the rest left to the model
    dir_tab.push_back(row(KIND_PEEK,  1, 64'h0, 1, 1, 64'h0, 0, 1023));  // empty
    dir_tab.push_back(row(KIND_DEQ,   8, 64'h0, 1, 1, 64'h0, 0, 1023));
    dir_tab.push_back(row(KIND_DEQ,   0, 64'h0, 1, 1, 64'h0, 0, 1023));  // zero count, empty
    dir_tab.push_back(row(KIND_ENQ,   0, 64'h0, 1, 0, 64'h0, 0, 1023));  // zero count
    dir_tab.push_back(row(KIND_ENQ,  15, '1,    1, 1, 64'h0, 0, 1023));  // count too large
    dir_tab.push_back(row(KIND_ENQ,   8, 64'h0123_4567_89AB_CDEF, 1, 0, 64'h0, 8, 1015));
    dir_tab.push_back(row(KIND_PEEK,  8, 64'h0, 1, 0, 64'h0123_4567_89AB_CDEF, 8, 1015));
    dir_tab.push_back(row(KIND_PEEK,  9, 64'h0, 1, 1, 64'h0, 8, 1015));
    dir_tab.push_back(row(KIND_DEQ,   0, 64'h0, 1, 0, 64'h0, 8, 1015));
    dir_tab.push_back(row(KIND_DEQ,   3, 64'h0, 1, 0, 64'hAB_CDEF, 5, 1018));
    dir_tab.push_back(row(KIND_PEEK,  5, 64'h0, 1, 0, 64'h01_2345_6789, 5, 1018));
    dir_tab.push_back(row(KIND_ENQ,   8, '1,    1, 0, 64'h0, 13, 1010));
    dir_tab.push_back(row(KIND_PEEK,  6, 64'h0, 0, 0, 64'h0, 0, 0));
    dir_tab.push_back(row(KIND_DEQ,   8, 64'h0, 1, 0, 64'hFFFF_FF01_2345_6789, 5, 1018));
    dir_tab.push_back(row(KIND_PEEK,  8, 64'h0, 1, 1, 64'h0, 5, 1018));  // too few held
    dir_tab.push_back(row(KIND_CLEAR, 15, '1,   1, 0, 64'h0, 0, 1023));  // clear ignores fields
    dir_tab.push_back(row(KIND_DEQ,   1, 64'h0, 1, 1, 64'h0, 0, 1023));
    dir_tab.push_back(row(KIND_ENQ,   8, 64'h0, 1, 0, 64'h0, 8, 1015));
    dir_tab.push_back(row(KIND_DEQ,  12, 64'h0, 1, 1, 64'h0, 8, 1015));
    dir_tab.push_back(row(KIND_PEEK, 15, 64'h0, 1, 1, 64'h0, 8, 1015));
    dir_tab.push_back(row(KIND_ENQ,   5, 64'hA5A5_5A5A_C3C3_3C3C, 0, 0, 64'h0, 0, 0));
    dir_tab.push_back(row(KIND_DEQ,   8, 64'h0, 0, 0, 64'h0, 0, 0));
    dir_tab.push_back(row(KIND_PEEK,  5, 64'h0, 0, 0, 64'h0, 0, 0));
    dir_tab.push_back(row(KIND_CLEAR, 0, 64'h0, 1, 0, 64'h0, 0, 1023));

    // synchronous reset, released at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[k]) begin
      it.kind       = dir_tab[k].kind;
      it.byte_count = dir_tab[k].cnt;
      it.data_in    = dir_tab[k].data;
      send_item(it, dir_tab[k].pinned, dir_tab[k].want);
    end

    // random phases: ring size, sender idle %, receiver stall %, clear %, items
    run_phase(32'd1024,       0,  0, 0, 190);  // fill the full-size ring to the brim
    run_phase(32'd2,         47,  0, 2,  60);  // smallest ring, capacity one byte
    run_phase(32'd9,          0, 47, 2, 100);  // capacity matches one full transfer
    run_phase(32'd2047,       9,  9, 1, 100);  // above range, acts as full size
    run_phase(32'd0,          0,  0, 2,  30);  // below range, acts as two slots
    run_phase(32'd17,        47,  0, 2,  80);
    run_phase(32'hFFFF_F805,  9,  9, 2,  60);  // junk above bit 10, five slots
    run_phase(32'd1,          0, 47, 2,  30);

    // waiting on after settling catches any stray result
    settle();
    repeat (4) @(posedge clk);

    $display("covered %0d items and %0d results over %0d ring sizes in %0d cycles",
             items_sent, results_checked, resizes, cycles);
    $display("full and empty rings, wrap-around, oversized and zero counts, clears");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_byte_ring_buffer_top: PASS");
    end else begin
      $display("%0d mismatches, %0d results never seen", mismatches,
               pending_results.size());
      $display("tb_byte_ring_buffer_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/brb_pkg.sv
src/brb_ram.sv
src/brb_lane.sv
src/brb_merge.sv
src/byte_ring_buffer_top.sv
tb/tb_byte_ring_buffer_top.sv
